// ===== src/pospid_pkg.sv =====
// pospid_pkg: shared types and constants of the positional PID controller.
// Holds the configuration register layout, field widths and beat kinds.
// No dependencies.
package pospid_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int GAIN_FRAC_DEF  = 8;

    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int INTEGRAL_W  = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [LIMIT_W-1:0] DEADBAND_RESET = LIMIT_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN        = 3'd0,
        CFG_KI_GAIN        = 3'd1,
        CFG_KD_GAIN        = 3'd2,
        CFG_OUTPUT_LIMIT   = 3'd3,
        CFG_INTEGRAL_BOUND = 3'd4,
        CFG_DEADBAND_WIDTH = 3'd5
    } t_cfg_index;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp_gain;
        logic signed [GAIN_W-1:0] ki_gain;
        logic signed [GAIN_W-1:0] kd_gain;
        logic [LIMIT_W-1:0]       output_limit;
        logic [LIMIT_W-1:0]       integral_bound;
        logic [LIMIT_W-1:0]       deadband_width;
    } t_cfg;

endpackage

// ===== src/position_pid_with_limits.sv =====
// position_pid_with_limits: positional PID controller, top level.
// Input register, control law with state, result register, config bank.
// Depends on pospid_pkg, pospid_cfg and pospid_law.
//
// Usage:
//   Slave stream carries samples: tdata = measured (low), target (high);
//   tuser = kind (sample or clear). Master stream returns one result per
//   input beat: tdata = drive, tuser = output_saturated.
//   Configuration is a plain write port (enable, index, data); the user
//   writes it only while no beat is in flight (the block does not enforce it).
// Timing:
//   A beat accepted into the input register passes through the whole control
//   law (three multiplies, sums, clamps, deadband) into the result register,
//   from which the result is offered.
//   Throughput is one beat per cycle while the receiver does not stall; the
//   integral and error update is made as each beat moves into the result register.
// Reset and stall:
//   Reset empties both registers, zeroes the integral and error history
//   and loads the default gains, limits and deadband. When the receiver
//   stalls, the result holds and one further beat waits in the input
//   register; tready drops only when both are full.
module position_pid_with_limits #(
    parameter int DATA_WIDTH     = pospid_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pospid_pkg::GAIN_FRAC_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pospid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pospid_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // measured, target
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    // kind
    input  logic                                  i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // drive
    output logic [((DATA_WIDTH+7)/8)*8-1:0]       o_m_tdata,
    // output_saturated
    output logic                                  o_m_tuser
);

    localparam int ODW = ((DATA_WIDTH + 7) / 8) * 8;

    pospid_pkg::t_cfg cfg;

    logic                         r_in_valid;
    logic                         r_in_kind;
    logic signed [DATA_WIDTH-1:0] r_in_measured;
    logic signed [DATA_WIDTH-1:0] r_in_target;
    logic                         r_out_valid;
    logic [DATA_WIDTH-1:0]        r_out_drive;
    logic                         r_out_sat;

    logic                         advance;
    logic                         step;
    logic [DATA_WIDTH-1:0]        law_drive;
    logic                         law_sat;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign step       = advance && r_in_valid;

    pospid_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pospid_law #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_law (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (step),
        .i_clear            (r_in_kind == pospid_pkg::KIND_CLEAR),
        .i_measured         (r_in_measured),
        .i_target           (r_in_target),
        .i_cfg              (cfg),
        .o_drive            (law_drive),
        .o_output_saturated (law_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_kind     <= i_s_tuser;
            r_in_measured <= signed'(i_s_tdata[DATA_WIDTH-1:0]);
            r_in_target   <= signed'(i_s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_drive <= law_drive;
            r_out_sat   <= law_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = ODW'(r_out_drive);
    assign o_m_tuser  = r_out_sat;

    a_clear_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_kind == pospid_pkg::KIND_CLEAR)
        |=> (r_out_drive == '0 && r_out_sat == 1'b0 && r_out_valid))
        else $error("clear beat did not give a zero result");

    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("waiting input beat lost");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed beat did not reach result register");

endmodule

// ===== src/pospid_cfg.sv =====
// pospid_cfg: configuration register bank of the PID controller.
// Takes plain register writes and presents them as one struct.
// Depends on pospid_pkg.
module pospid_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pospid_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pospid_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pospid_pkg::t_cfg                    o_cfg
);

    pospid_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain        <= '0;
            r_cfg.ki_gain        <= '0;
            r_cfg.kd_gain        <= '0;
            r_cfg.output_limit   <= '0;
            r_cfg.integral_bound <= '0;
            r_cfg.deadband_width <= pospid_pkg::DEADBAND_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pospid_pkg::CFG_KP_GAIN: begin
                    r_cfg.kp_gain <= signed'(i_cfg_data[pospid_pkg::GAIN_W-1:0]);
                end
                pospid_pkg::CFG_KI_GAIN: begin
                    r_cfg.ki_gain <= signed'(i_cfg_data[pospid_pkg::GAIN_W-1:0]);
                end
                pospid_pkg::CFG_KD_GAIN: begin
                    r_cfg.kd_gain <= signed'(i_cfg_data[pospid_pkg::GAIN_W-1:0]);
                end
                pospid_pkg::CFG_OUTPUT_LIMIT: begin
                    r_cfg.output_limit <= i_cfg_data[pospid_pkg::LIMIT_W-1:0];
                end
                pospid_pkg::CFG_INTEGRAL_BOUND: begin
                    r_cfg.integral_bound <= i_cfg_data[pospid_pkg::LIMIT_W-1:0];
                end
                pospid_pkg::CFG_DEADBAND_WIDTH: begin
                    r_cfg.deadband_width <= i_cfg_data[pospid_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/pospid_law.sv =====
// pospid_law: control law of the PID controller with its loop state.
// Error, P/I/D products, integral and output clamps, deadband; holds the
// integral and previous error. Depends on pospid_pkg.
module pospid_law #(
    parameter int DATA_WIDTH     = pospid_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pospid_pkg::GAIN_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_clear,
    input  logic signed [DATA_WIDTH-1:0]  i_measured,
    input  logic signed [DATA_WIDTH-1:0]  i_target,
    input  pospid_pkg::t_cfg              i_cfg,
    output logic [DATA_WIDTH-1:0]         o_drive,
    output logic                          o_output_saturated
);

    localparam int GW  = pospid_pkg::GAIN_W;
    localparam int LW  = pospid_pkg::LIMIT_W;
    localparam int IW  = pospid_pkg::INTEGRAL_W;
    localparam int EW  = DATA_WIDTH + 1;
    localparam int DEW = DATA_WIDTH + 2;
    localparam int SW0 = GW + DATA_WIDTH + 4;
    localparam int SW  = (SW0 > IW + 2) ? SW0 : IW + 2;
    localparam int LSW = LW + GAIN_FRAC_BITS + 1;
    localparam int CW  = ((SW > LSW) ? SW : LSW) + 1;

    localparam logic signed [CW-1:0] IMAX = signed'(CW'({(IW-1){1'b1}}));
    localparam logic signed [CW-1:0] IMIN = ~IMAX;

    logic signed [IW-1:0]     r_integral;
    logic signed [EW-1:0]     r_prev_err;

    logic signed [EW-1:0]     err;
    logic signed [DEW-1:0]    derr;
    logic signed [GW+EW-1:0]  p_term;
    logic signed [GW+EW-1:0]  i_inc;
    logic signed [GW+DEW-1:0] d_term;
    logic signed [SW-1:0]     itot;
    logic signed [SW-1:0]     sum;
    logic signed [CW-1:0]     itot_c;
    logic signed [CW-1:0]     sum_c;
    logic signed [CW-1:0]     ibound;
    logic signed [CW-1:0]     olimit;
    logic signed [CW-1:0]     iclamp;
    logic signed [CW-1:0]     isat;
    logic signed [CW-1:0]     clamped;
    logic                     sat;
    logic [CW-1:0]            mag;
    logic [CW-1:0]            db_thr;
    logic [CW-1:0]            mag_db;
    logic [CW-1:0]            mag_int;
    logic [CW-1:0]            drive_full;
    logic signed [IW-1:0]     n_integral;

    assign err    = EW'(i_target) - EW'(i_measured);
    assign derr   = DEW'(err) - DEW'(r_prev_err);
    assign p_term = (GW+EW)'(i_cfg.kp_gain) * (GW+EW)'(err);
    assign i_inc  = (GW+EW)'(i_cfg.ki_gain) * (GW+EW)'(err);
    assign d_term = (GW+DEW)'(i_cfg.kd_gain) * (GW+DEW)'(derr);
    assign itot   = SW'(r_integral) + SW'(i_inc);
    assign sum    = SW'(p_term) + itot + SW'(d_term);

    assign itot_c = CW'(itot);
    assign sum_c  = CW'(sum);
    assign ibound = signed'(CW'(i_cfg.integral_bound) << GAIN_FRAC_BITS);
    assign olimit = signed'(CW'(i_cfg.output_limit) << GAIN_FRAC_BITS);
    assign db_thr = CW'(i_cfg.deadband_width) << GAIN_FRAC_BITS;

    always_comb begin
        if (itot_c > ibound) begin
            iclamp = ibound;
        end else if (itot_c < -ibound) begin
            iclamp = -ibound;
        end else begin
            iclamp = itot_c;
        end
        if (iclamp > IMAX) begin
            isat = IMAX;
        end else if (iclamp < IMIN) begin
            isat = IMIN;
        end else begin
            isat = iclamp;
        end
        n_integral = IW'(isat);

        if (sum_c > olimit) begin
            clamped = olimit;
            sat     = 1'b1;
        end else if (sum_c < -olimit) begin
            clamped = -olimit;
            sat     = 1'b1;
        end else begin
            clamped = sum_c;
            sat     = 1'b0;
        end

        mag = clamped[CW-1] ? unsigned'(-clamped) : unsigned'(clamped);
        if ((i_cfg.deadband_width != '0) && (mag < db_thr)) begin
            mag_db = '0;
        end else begin
            mag_db = mag;
        end
        mag_int    = mag_db >> GAIN_FRAC_BITS;
        drive_full = clamped[CW-1] ? (~mag_int + CW'(1)) : mag_int;

        if (i_clear) begin
            o_drive            = '0;
            o_output_saturated = 1'b0;
        end else begin
            o_drive            = drive_full[DATA_WIDTH-1:0];
            o_output_saturated = sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev_err <= '0;
        end else if (i_en) begin
            if (i_clear) begin
                r_integral <= '0;
                r_prev_err <= '0;
            end else begin
                r_integral <= n_integral;
                r_prev_err <= err;
            end
        end
    end

    a_clear_zeroes_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_clear) |=> (r_integral == '0 && r_prev_err == '0))
        else $error("loop state not zeroed by clear beat");

    a_state_holds_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_integral) && $stable(r_prev_err)))
        else $error("loop state changed without a beat");

endmodule

// ===== tb/tb_position_pid_with_limits.sv =====
// tb_position_pid_with_limits: self-checking testbench for the positional PID controller.
// Drives sample and clear beats with random gaps, predicts each result, compares on arrival.
// Depends on pospid_pkg and position_pid_with_limits.
module tb_position_pid_with_limits;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW    = pospid_pkg::DATA_WIDTH_DEF;
    localparam int FRAC  = pospid_pkg::GAIN_FRAC_DEF;
    localparam int IDX_W = pospid_pkg::CFG_IDX_W;
    localparam int CD_W  = pospid_pkg::CFG_DATA_W;
    localparam int IN_W  = ((2*DW+7)/8)*8;
    localparam int OUT_W = ((DW+7)/8)*8;
    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam longint INTEG_MAX = (longint'(1) << (pospid_pkg::INTEGRAL_W-1)) - 1;

    typedef struct {
        logic                 kind;
        logic signed [DW-1:0] measured;
        logic signed [DW-1:0] target;
    } t_sample;

    typedef struct {
        logic signed [DW-1:0] drive;
        logic                 saturated;
    } t_drive;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CD_W-1:0]  i_cfg_data = '0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata = '0;
    logic             i_s_tuser = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;
    logic             o_m_tuser;

    t_sample sample_q[$];
    t_drive  drive_due_q[$];
    t_sample next_sample;
    t_drive  want;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      mismatch_count = 0;

    logic signed [pospid_pkg::GAIN_W-1:0] kp_q = '0;
    logic signed [pospid_pkg::GAIN_W-1:0] ki_q = '0;
    logic signed [pospid_pkg::GAIN_W-1:0] kd_q = '0;
    logic [pospid_pkg::LIMIT_W-1:0]       out_limit_q = '0;
    logic [pospid_pkg::LIMIT_W-1:0]       integ_bound_q = '0;
    logic [pospid_pkg::LIMIT_W-1:0]       deadband_q = pospid_pkg::DEADBAND_RESET;
    longint                               integ_acc = 0;
    longint                               err_hist = 0;

    position_pid_with_limits dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // measured, target
        .i_s_tuser   (i_s_tuser),   // kind
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // drive
        .o_m_tuser   (o_m_tuser)    // output_saturated
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_drive pid_law(logic kind, logic signed [DW-1:0] measured,
                                       logic signed [DW-1:0] target);
        longint err, total, itot, ibound, lim, clamped, mag;
        t_drive r;
        r.drive = '0;
        r.saturated = 1'b0;
        if (kind == pospid_pkg::KIND_CLEAR) begin
            integ_acc = 0;
            err_hist = 0;
            return r;
        end
        err = longint'(target) - longint'(measured);
        itot = integ_acc + longint'(ki_q) * err;
        total = longint'(kp_q) * err + itot + longint'(kd_q) * (err - err_hist);
        ibound = longint'(integ_bound_q) << FRAC;
        integ_acc = (itot > ibound) ? ibound : (itot < -ibound) ? -ibound : itot;
        if (integ_acc > INTEG_MAX)
            integ_acc = INTEG_MAX;
        if (integ_acc < -INTEG_MAX - 1)
            integ_acc = -INTEG_MAX - 1;
        err_hist = err;
        lim = longint'(out_limit_q) << FRAC;
        r.saturated = (total > lim) || (total < -lim);
        clamped = (total > lim) ? lim : (total < -lim) ? -lim : total;
        mag = (clamped < 0) ? -clamped : clamped;
        if (deadband_q != 0 && mag < (longint'(deadband_q) << FRAC))
            mag = 0;
        mag = mag >>> FRAC;
        r.drive = DW'((clamped < 0) ? -mag : mag);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // driver: advance to the next beat once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_sample = sample_q.pop_front();
                i_s_tdata  <= IN_W'({next_sample.target, next_sample.measured});
                i_s_tuser  <= next_sample.kind;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on input beats, check on output beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                drive_due_q.push_back(pid_law(i_s_tuser, i_s_tdata[DW-1:0],
                                              i_s_tdata[2*DW-1:DW]));
            if (o_m_tvalid && i_m_tready) begin
                if (drive_due_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat, drive %0d sat %0b",
                                              $signed(o_m_tdata[DW-1:0]), o_m_tuser));
                end else begin
                    want = drive_due_q.pop_front();
                    if (o_m_tdata[DW-1:0] !== want.drive)
                        report_mismatch($sformatf("drive %0d, want %0d",
                                                  $signed(o_m_tdata[DW-1:0]), want.drive));
                    if (o_m_tuser !== want.saturated)
                        report_mismatch($sformatf("saturated %0b, want %0b",
                                                  o_m_tuser, want.saturated));
                end
            end
        end
    end

    task automatic push_sample(input logic kind, input int measured, input int target);
        t_sample s;
        s.kind = kind;
        s.measured = DW'(measured);
        s.target = DW'(target);
        sample_q.push_back(s);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || i_s_tvalid || drive_due_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CD_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            pospid_pkg::CFG_KP_GAIN:        kp_q = value;
            pospid_pkg::CFG_KI_GAIN:        ki_q = value;
            pospid_pkg::CFG_KD_GAIN:        kd_q = value;
            pospid_pkg::CFG_OUTPUT_LIMIT:   out_limit_q = value[pospid_pkg::LIMIT_W-1:0];
            pospid_pkg::CFG_INTEGRAL_BOUND: integ_bound_q = value[pospid_pkg::LIMIT_W-1:0];
            pospid_pkg::CFG_DEADBAND_WIDTH: deadband_q = value[pospid_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input logic [15:0] kp, input logic [15:0] ki, input logic [15:0] kd,
                             input logic [15:0] lim, input logic [15:0] bound,
                             input logic [15:0] dead);
        wait_idle();
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
        write_reg(pospid_pkg::CFG_KP_GAIN, kp);
        write_reg(pospid_pkg::CFG_KI_GAIN, ki);
        write_reg(pospid_pkg::CFG_KD_GAIN, kd);
        write_reg(pospid_pkg::CFG_OUTPUT_LIMIT, lim);
        write_reg(pospid_pkg::CFG_INTEGRAL_BOUND, bound);
        write_reg(pospid_pkg::CFG_DEADBAND_WIDTH, dead);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(1024) - 512);
            2:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom_range(300));
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(4))
            0:       return 16'($urandom_range(1) << 15);
            1:       return 16'h7FFF | 16'($urandom_range(1) << 15);
            2:       return 16'($urandom);
            default: return 16'($urandom_range(4000));
        endcase
    endfunction

    function automatic logic [15:0] pick_deadband();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'($urandom);
            default: return 16'($urandom_range(40));
        endcase
    endfunction

    function automatic int clip16(int v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    // mostly settling runs towards a held target, with clears and noise between
    task automatic add_samples(input int n);
        int count, run_len, target, meas, k;
        count = 0;
        while (count < n) begin
            k = $urandom_range(99);
            if (k < 8) begin
                push_sample(pospid_pkg::KIND_CLEAR, $urandom, $urandom);
                count++;
            end else if (k < 25) begin
                push_sample(pospid_pkg::KIND_SAMPLE, $urandom, $urandom);
                count++;
            end else begin
                target = $signed(16'($urandom));
                meas = clip16(target + int'($urandom_range(4000)) - 2000);
                run_len = $urandom_range(16, 4);
                for (int j = 0; j < run_len && count < n; j++) begin
                    push_sample(pospid_pkg::KIND_SAMPLE, meas, target);
                    count++;
                    meas = clip16(meas + (target - meas) / 2 + int'($urandom_range(6)) - 3);
                end
            end
        end
    endtask

    initial begin
        send_idle_pct = 31;
        recv_idle_pct = 78;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: zero gains, zero limit, deadband 5
        push_sample(pospid_pkg::KIND_SAMPLE, -32768, 32767);
        push_sample(pospid_pkg::KIND_SAMPLE, 32767, -32768);
        push_sample(pospid_pkg::KIND_SAMPLE, 0, 0);

        apply_cfg(16'd256, 16'd64, 16'd128, 16'd1000, 16'd200, 16'd5);
        push_sample(pospid_pkg::KIND_SAMPLE, 0, 0);
        push_sample(pospid_pkg::KIND_SAMPLE, 0, 1);
        push_sample(pospid_pkg::KIND_SAMPLE, 0, 10);
        repeat (3) push_sample(pospid_pkg::KIND_SAMPLE, 0, 3000);
        push_sample(pospid_pkg::KIND_SAMPLE, -32768, 32767);
        push_sample(pospid_pkg::KIND_SAMPLE, 32767, -32768);
        push_sample(pospid_pkg::KIND_CLEAR, 0, 0);
        push_sample(pospid_pkg::KIND_SAMPLE, 0, -3000);

        apply_cfg(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
        push_sample(pospid_pkg::KIND_SAMPLE, -32768, 32767);
        push_sample(pospid_pkg::KIND_SAMPLE, 32767, -32768);
        push_sample(pospid_pkg::KIND_SAMPLE, 100, -100);

        apply_cfg(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF);
        push_sample(pospid_pkg::KIND_SAMPLE, 5, -7);
        push_sample(pospid_pkg::KIND_SAMPLE, 0, 0);
        push_sample(pospid_pkg::KIND_SAMPLE, -32768, 32767);
        push_sample(pospid_pkg::KIND_CLEAR, -1, -1);

        for (int seg = 0; seg < 9; seg++) begin
            apply_cfg(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
                      pick_deadband());
            send_idle_pct = (seg < 3) ? 31 : (seg < 6) ? 78 : 0;
            recv_idle_pct = (seg < 3) ? 78 : (seg < 6) ? 31 : 0;
            add_samples(50);
            // hold the sender until every result is back
            wait_idle();
            add_samples(50);
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("PASS position_pid_with_limits");
        else
            $display("FAIL position_pid_with_limits");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("FAIL position_pid_with_limits");
        $finish;
    end

endmodule
